>>> design/prrs_pkg.sv
`timescale 1ns / 1ps
package prrs_pkg;
  localparam int SLOTS = 8;
  localparam int LEVELS = 8;
  localparam int TICK_BITS = 32;
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(LEVELS);
  localparam int CW = SW + 1;

  localparam logic [2:0] FUNC_READY = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_TICK = 3'd2;
  localparam logic [2:0] FUNC_SWITCH = 3'd3;
  localparam logic [2:0] FUNC_SLEEP = 3'd4;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_TICK_OVF = 2'd1;
  localparam logic [1:0] ERR_WAKE_OVF = 2'd2;
  localparam logic [1:0] ERR_NO_READY = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UNLINK_PRED,
    ST_UNLINK,
    ST_SLEEP_UNLINK,
    ST_LINK_PRED,
    ST_LINK,
    ST_TICK_SCAN,
    ST_TICK_WAKE,
    ST_SWITCH_SCAN,
    ST_SLEEP_ENTER,
    ST_DONE
  } state_t;
endpackage

>>> design/prrs_pred_walk.sv
`timescale 1ns / 1ps
module prrs_pred_walk (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic [prrs_pkg::SW-1:0] target,
  input  logic [prrs_pkg::SLOTS-1:0][prrs_pkg::SW-1:0] succ,
  output logic done,
  output logic [prrs_pkg::SW-1:0] pred
);
  import prrs_pkg::*;

  logic busy;
  logic [SW-1:0] cur;
  logic [CW-1:0] steps;
  logic [SW-1:0] nxt;

  assign nxt = succ[cur];
  assign pred = cur;
  assign done = busy && ((nxt == target) || (steps == CW'(SLOTS - 1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      steps <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cur <= target;
      steps <= '0;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
      end else begin
        cur <= nxt;
        steps <= steps + CW'(1);
      end
    end
  end
endmodule

>>> design/priority_round_robin_scheduler.sv
`timescale 1ns / 1ps
// A command is accepted when start is high and busy is low. Its result beat (done high)
// follows once the command's states are through. An enabled tick scans all eight slots for
// a slot that is due to wake, relinks it and scans again until none is due. An unlink or a
// relink may need a ring predecessor walk. The next command is accepted at the earliest at
// the edge that ends the result beat. The receiver cannot stall. Synchronous active-high
// reset empties all rings and the sleep list and clears the tick count, the running slot
// and the enable register.
module priority_round_robin_scheduler (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [2:0] func,
  input  logic [2:0] thread_id,
  input  logic [2:0] priority_req,
  input  logic [31:0] wait_time,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output logic done,
  output logic [2:0] running_id,
  output logic running_valid,
  output logic switch_request,
  output logic [3:0] woken_count,
  output logic [1:0] error_code
);
  import prrs_pkg::*;

  state_t state, state_next;
  logic enabled;
  logic [TICK_BITS-1:0] tick_count;
  logic [SLOTS-1:0][LW-1:0] slot_priority;
  logic [SLOTS-1:0] slot_ready, slot_sleeping;
  logic [SLOTS-1:0][TICK_BITS-1:0] slot_wake_tick;
  logic [SLOTS-1:0][SW:0] slot_sleep_order;
  logic [SLOTS-1:0][SW-1:0] ring_successor;
  logic [LEVELS-1:0][SW:0] ring_cursor;
  logic [SW-1:0] running_slot;
  logic running_present;
  logic [LW-1:0] top_priority;

  logic [2:0] op;
  logic [SW-1:0] slot;
  logic [LW-1:0] new_prio;
  logic [TICK_BITS-1:0] wait_reg;
  logic sw_acc;
  logic [3:0] woken;
  logic [1:0] err;
  logic relink;
  logic [SW:0] scan_idx;
  logic [SW:0] best;
  logic [LW:0] lvl;

  logic walk_go, walk_done;
  logic [SW-1:0] walk_target, walk_pred;

  prrs_pred_walk u_walk (
    .clk(clk), .rst(rst), .go(walk_go), .target(walk_target),
    .succ(ring_successor), .done(walk_done), .pred(walk_pred)
  );

  logic [LW-1:0] sp;
  logic [SW:0] cur_c;
  logic [SW:0] link_c;
  logic [SW:0] sleep_cnt;
  logic scan_better;
  logic [SW-1:0] si;

  assign sp = slot_priority[slot];
  assign cur_c = ring_cursor[sp];
  assign link_c = ring_cursor[new_prio];
  assign si = scan_idx[SW-1:0];

  always_comb begin
    sleep_cnt = '0;
    for (int i = 0; i < SLOTS; i++) sleep_cnt = sleep_cnt + (SW+1)'(slot_sleeping[i]);
  end

  always_comb begin
    scan_better = 1'b0;
    if (slot_sleeping[si] && slot_wake_tick[si] <= tick_count) begin
      if (best[SW]) scan_better = 1'b1;
      else if (slot_wake_tick[si] < slot_wake_tick[best[SW-1:0]]) scan_better = 1'b1;
      else if (slot_wake_tick[si] == slot_wake_tick[best[SW-1:0]] &&
               slot_sleep_order[si] < slot_sleep_order[best[SW-1:0]]) scan_better = 1'b1;
    end
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    walk_go = 1'b0;
    walk_target = slot;
    case (state)
      ST_IDLE: if (start) state_next = ST_DECODE;
      ST_DECODE: begin
        case (op)
          FUNC_READY, FUNC_REMOVE: begin
            if (slot_ready[slot] && !cur_c[SW]) begin
              walk_go = 1'b1;
              state_next = ST_UNLINK_PRED;
            end else begin
              state_next = ST_UNLINK;
            end
          end
          FUNC_TICK: state_next = enabled ? ST_TICK_SCAN : ST_DONE;
          FUNC_SWITCH: state_next = ST_SWITCH_SCAN;
          FUNC_SLEEP: begin
            if (!running_present || !slot_ready[running_slot]) begin
              state_next = ST_DONE;
            end else if (!cur_c[SW]) begin
              walk_go = 1'b1;
              state_next = ST_UNLINK_PRED;
            end else begin
              state_next = ST_UNLINK;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_UNLINK_PRED: if (walk_done) state_next = ST_UNLINK;
      ST_UNLINK: state_next = (op == FUNC_SLEEP) ? ST_SLEEP_ENTER : ST_SLEEP_UNLINK;
      ST_SLEEP_UNLINK: begin
        if (op == FUNC_REMOVE) begin
          state_next = ST_DONE;
        end else if (!link_c[SW]) begin
          walk_go = 1'b1;
          walk_target = link_c[SW-1:0];
          state_next = ST_LINK_PRED;
        end else begin
          state_next = ST_LINK;
        end
      end
      ST_LINK_PRED: begin
        walk_target = link_c[SW-1:0];
        if (walk_done) state_next = ST_LINK;
      end
      ST_LINK: state_next = relink ? ST_TICK_SCAN : ST_DONE;
      ST_TICK_SCAN: begin
        if (scan_idx == (SW+1)'(SLOTS - 1)) begin
          if (best[SW] && !scan_better) state_next = ST_DONE;
          else state_next = ST_TICK_WAKE;
        end
      end
      ST_TICK_WAKE: state_next = ST_SLEEP_UNLINK;
      ST_SWITCH_SCAN: begin
        if (lvl[LW] || !ring_cursor[lvl[LW-1:0]][SW]) state_next = ST_DONE;
      end
      ST_SLEEP_ENTER: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      tick_count <= '0;
      slot_ready <= '0;
      slot_sleeping <= '0;
      for (int i = 0; i < LEVELS; i++) ring_cursor[i] <= (SW+1)'(SLOTS);
      running_slot <= '0;
      running_present <= 1'b0;
      top_priority <= LW'(LEVELS - 1);
      done <= 1'b0;
    end else begin
      if (cfg_we) enabled <= cfg_wdata;
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            op <= func;
            slot <= (func == FUNC_SLEEP) ? running_slot : thread_id;
            new_prio <= priority_req;
            wait_reg <= (wait_time == '0) ? TICK_BITS'(1) : wait_time;
            sw_acc <= 1'b0;
            woken <= '0;
            err <= ERR_OK;
            relink <= 1'b0;
          end
        end
        ST_DECODE: begin
          if (op == FUNC_SLEEP) begin
            slot <= running_slot;
            if (!running_present || !slot_ready[running_slot]) err <= ERR_NO_READY;
          end else if (op == FUNC_TICK && enabled) begin
            tick_count <= tick_count + TICK_BITS'(1);
            if (tick_count == '1) err <= ERR_TICK_OVF;
            scan_idx <= '0;
            best <= (SW+1)'(SLOTS);
          end else if (op == FUNC_SWITCH) begin
            lvl <= {1'b0, top_priority};
          end
        end
        ST_UNLINK: begin
          if (slot_ready[slot]) begin
            slot_ready[slot] <= 1'b0;
            if (!cur_c[SW]) begin
              if (walk_pred == slot) begin
                ring_cursor[sp] <= (SW+1)'(SLOTS);
              end else begin
                ring_successor[walk_pred] <= ring_successor[slot];
                if (cur_c[SW-1:0] == slot) ring_cursor[sp] <= {1'b0, walk_pred};
              end
            end
          end
          if (op == FUNC_REMOVE && running_present && running_slot == slot) sw_acc <= 1'b1;
        end
        ST_SLEEP_UNLINK: begin
          if (slot_sleeping[slot]) begin
            slot_sleeping[slot] <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
              if (slot_sleeping[i] && slot_sleep_order[i] > slot_sleep_order[slot])
                slot_sleep_order[i] <= slot_sleep_order[i] - (SW+1)'(1);
          end
          if (!relink && op == FUNC_READY) slot_priority[slot] <= new_prio;
        end
        ST_LINK: begin
          if (link_c[SW]) begin
            ring_successor[slot] <= slot;
            ring_cursor[new_prio] <= {1'b0, slot};
          end else begin
            ring_successor[walk_pred] <= slot;
            ring_successor[slot] <= link_c[SW-1:0];
          end
          slot_ready[slot] <= 1'b1;
          if (new_prio < top_priority) top_priority <= new_prio;
          if (running_present && new_prio < slot_priority[running_slot]) sw_acc <= 1'b1;
          scan_idx <= '0;
          best <= (SW+1)'(SLOTS);
        end
        ST_TICK_SCAN: begin
          if (scan_better) best <= scan_idx;
          scan_idx <= scan_idx + (SW+1)'(1);
          if (scan_idx == (SW+1)'(SLOTS - 1)) begin
            slot <= scan_better ? si : best[SW-1:0];
          end
        end
        ST_TICK_WAKE: begin
          relink <= 1'b1;
          new_prio <= slot_priority[slot];
          if (woken != 4'd15) woken <= woken + 4'd1;
        end
        ST_SWITCH_SCAN: begin
          if (lvl[LW]) begin
            top_priority <= LW'(LEVELS - 1);
            err <= ERR_NO_READY;
          end else if (!ring_cursor[lvl[LW-1:0]][SW]) begin
            top_priority <= lvl[LW-1:0];
            ring_cursor[lvl[LW-1:0]] <=
              {1'b0, ring_successor[ring_cursor[lvl[LW-1:0]][SW-1:0]]};
            running_slot <= ring_successor[ring_cursor[lvl[LW-1:0]][SW-1:0]];
            running_present <= 1'b1;
          end else begin
            lvl <= lvl + (LW+1)'(1);
          end
        end
        ST_SLEEP_ENTER: begin
          if (wait_reg > ~tick_count) begin
            slot_wake_tick[slot] <= '1;
            err <= ERR_WAKE_OVF;
          end else begin
            slot_wake_tick[slot] <= tick_count + wait_reg;
          end
          slot_sleep_order[slot] <= sleep_cnt;
          slot_sleeping[slot] <= 1'b1;
          sw_acc <= 1'b1;
        end
        ST_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  assign running_id = running_slot;
  assign running_valid = running_present;
  assign switch_request = sw_acc;
  assign woken_count = woken;
  assign error_code = err;
endmodule
